>>> rtl/assert_macros.svh
// Assertion helpers shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SSFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define SSFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> rtl/ssfs_pkg.sv
`default_nettype none
package ssfs_pkg;

    localparam logic [7:0] SEG_DASH   = 8'hBF;
    localparam logic [7:0] SEG_CHOOSE = 8'hF7;
    localparam logic [7:0] SEG_MATCH  = 8'h7F;
    localparam logic [7:0] SEG_OFF    = 8'hFF;
    localparam logic [7:0] SEL_MARKER = 8'h01;
    localparam logic [7:0] SEL_OFF    = 8'h00;
    localparam logic [3:0] SEL_START  = 4'h8;

    // Reciprocal of ten for 16-bit operands: q = (x * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [1:0] KIND_SLEEP  = 2'd0;
    localparam logic [1:0] KIND_PLAIN  = 2'd1;
    localparam logic [1:0] KIND_CHOOSE = 2'd2;
    localparam logic [1:0] KIND_MATCH  = 2'd3;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  kind;
    } in_item_t;

    typedef struct packed {
        logic [7:0] digit_select;
        logic [7:0] segments;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MARKER,
        S_DASH,
        S_DIGITS,
        S_OFF
    } state_t;

    typedef enum logic [1:0] {
        FRM_MARKER,
        FRM_DASH,
        FRM_DIGIT,
        FRM_OFF
    } frame_t;

    typedef struct packed {
        logic   load;
        logic   emit;
        frame_t frame;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic       rem_lt10;
        logic       sel_last;
        logic [1:0] kind;
    } dp_status_t;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0: g = 8'hC0;
            4'd1: g = 8'hCF;
            4'd2: g = 8'hA4;
            4'd3: g = 8'hB0;
            4'd4: g = 8'h99;
            4'd5: g = 8'h92;
            4'd6: g = 8'h82;
            4'd7: g = 8'hF8;
            4'd8: g = 8'h80;
            4'd9: g = 8'h90;
            default: g = SEG_OFF;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ssfs_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module ssfs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ssfs_pkg::dp_status_t status,
    output ssfs_pkg::ctrl_cmd_t      cmd
);
    import ssfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.frame  = FRM_OFF;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                case (status.kind)
                    KIND_SLEEP:  state_next = S_DASH;
                    KIND_PLAIN:  state_next = S_DIGITS;
                    KIND_CHOOSE: state_next = S_MARKER;
                    KIND_MATCH:  state_next = S_MARKER;
                    default:     state_next = S_DIGITS;
                endcase
            end
            S_MARKER: begin
                cmd.frame = FRM_MARKER;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_DIGITS;
                end
            end
            S_DASH: begin
                cmd.frame = FRM_DASH;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.sel_last) begin
                        state_next = S_OFF;
                    end
                end
            end
            S_DIGITS: begin
                cmd.frame = FRM_DIGIT;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.rem_lt10) begin
                        state_next = S_OFF;
                    end
                end
            end
            S_OFF: begin
                cmd.frame = FRM_OFF;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SSFS_ASSERT(a_off_ends_run,
        (cmd.emit && cmd.frame == FRM_OFF) |=> (state_reg == S_IDLE),
        "closing frame did not return the controller to idle")

endmodule
`default_nettype wire

>>> rtl/ssfs_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module ssfs_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ssfs_pkg::in_item_t  s_item,
    input  wire ssfs_pkg::ctrl_cmd_t cmd,
    output ssfs_pkg::dp_status_t     status,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ssfs_pkg::out_item_t      m_item
);
    import ssfs_pkg::*;

    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [3:0]  select_reg;
    logic [3:0]  select_next;
    logic [1:0]  kind_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    out_item_t   m_item_reg;
    out_item_t   m_item_next;

    logic [32:0] product;
    logic [15:0] quotient;
    logic [15:0] times_ten;
    logic [15:0] difference;
    logic [3:0]  rem_digit;
    logic        out_free;

    // Divide by ten through the reciprocal; the remainder follows from q*10 = q*8 + q*2.
    assign product    = {17'd0, remaining_reg} * {16'd0, RECIP_TEN};
    assign quotient   = {2'd0, product[32:RECIP_SHIFT]};
    assign times_ten  = {quotient[12:0], 3'd0} + {quotient[14:0], 1'd0};
    assign difference = remaining_reg - times_ten;
    assign rem_digit  = difference[3:0];

    assign out_free = !m_valid_reg || m_ready;

    assign status.out_free = out_free;
    assign status.rem_lt10 = (quotient == 16'd0);
    assign status.sel_last = select_reg[0];
    assign status.kind     = kind_reg;

    always_comb begin
        remaining_next = remaining_reg;
        select_next    = select_reg;
        m_item_next    = m_item_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (cmd.load) begin
            remaining_next = s_item.value;
            select_next    = SEL_START;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            case (cmd.frame)
                FRM_MARKER: begin
                    m_item_next.digit_select = SEL_MARKER;
                    m_item_next.segments     = (kind_reg == KIND_CHOOSE) ? SEG_CHOOSE
                                                                          : SEG_MATCH;
                    m_item_next.last         = 1'b0;
                end
                FRM_DASH: begin
                    m_item_next.digit_select = {4'd0, select_reg};
                    m_item_next.segments     = SEG_DASH;
                    m_item_next.last         = 1'b0;
                    select_next              = {1'b0, select_reg[3:1]};
                end
                FRM_DIGIT: begin
                    m_item_next.digit_select = {4'd0, select_reg};
                    m_item_next.segments     = digit_glyph(rem_digit);
                    m_item_next.last         = 1'b0;
                    select_next              = {1'b0, select_reg[3:1]};
                    remaining_next           = quotient;
                end
                FRM_OFF: begin
                    m_item_next.digit_select = SEL_OFF;
                    m_item_next.segments     = SEG_OFF;
                    m_item_next.last         = 1'b1;
                end
                default: begin
                    m_item_next = m_item_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            select_reg    <= SEL_START;
            remaining_reg <= 16'd0;
        end else begin
            m_valid_reg   <= m_valid_next;
            select_reg    <= select_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (cmd.load) begin
            kind_reg <= s_item.kind;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `SSFS_ASSERT(a_emit_needs_room,
        cmd.emit |-> out_free,
        "frame written over a result that was not taken")
    `SSFS_ASSERT(a_select_onehot0,
        $onehot0(select_reg),
        "digit select register is not one-hot or zero")
    `SSFS_ASSERT(a_remainder_decimal,
        (difference < 16'd10),
        "reciprocal divide produced a remainder of ten or more")

endmodule
`default_nettype wire

>>> rtl/seven_segment_frame_sequencer.sv
`default_nettype none
// Seven-segment frame sequencer. Each input transaction carries a 16-bit value and a
// two-bit kind; the block answers with a run of (digit_select, segments) frames for a
// common-anode display behind a shift register, closed by an all-off frame that has
// last set. Sleep kind sends four dashes on selects 0x08, 0x04, 0x02, 0x01. The other
// kinds send the decimal digits least significant first on selects that start at 0x08
// and shift right, a single 0 for a value of zero, and a fifth digit (values of 10000
// and up) on select 0. The choose and match kinds first send one marker frame on
// select 0x01. Segment bytes are active low with the decimal point in bit 7. One
// transaction is worked at a time: after acceptance the controller chooses the path in
// S_START and then sends one frame per cycle while the output register is free; a run
// holds from 2 to 7 frames. The limit is the single output register, which holds one
// frame and is refilled in the cycle it is taken. The controller returns to idle at the
// edge that writes the closing frame, so it can accept the next input transaction in
// the following cycle, while that frame may still be waiting on m_ready.
module seven_segment_frame_sequencer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ssfs_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ssfs_pkg::out_item_t      m_item
);
    import ssfs_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller: walks marker, dash, digit and closing phases of each run.
    ssfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: remaining value, select shifter, divide-by-ten and the output register.
    ssfs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire
